/* design/smm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

    // Field widths of the stream payloads
    localparam int VAL_W = 16;
    localparam int IDX_W = 3;
    localparam int CFG_W = 16;
    localparam int CFG_AW = 3;
    localparam int SIZE_W = 4;
    // Wide enough for any size limit or inner index (sizes up to 64)
    localparam int LIM_W = 7;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_ALPHA   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BETA    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ROWS_M  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_INNER_K = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_COLS_N  = 3'd4;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Operation handed to the shared multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic clear;
    } mac_op_t;

endpackage

`default_nettype wire

/* design/smm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module smm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [smm_pkg::VAL_W-1:0]  wdata,
    input  wire logic [AW-1:0]              raddr,
    output logic      [smm_pkg::VAL_W-1:0]  rdata
);
    import smm_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/smm_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module smm_mac #(
    parameter int Y_W   = 28,
    parameter int ACC_W = 45
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire smm_pkg::mac_op_t                  op,
    input  wire logic signed [smm_pkg::VAL_W-1:0]  x,
    input  wire logic signed [Y_W-1:0]             y,
    output logic                                   busy,
    output logic signed [ACC_W-1:0]                acc
);
    import smm_pkg::*;

    localparam int PROD_W = VAL_W + Y_W;

    mac_op_t                   op_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    // Accumulate stage: optionally restart from zero
    always_comb begin
        acc_next = op_reg.clear ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
    end

    // Multiply stage, then accumulate stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= '0;
        end else begin
            op_reg <= op;
        end
        prod_reg <= x * y;
        if (op_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign busy = op_reg.valid;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

/* design/scaled_matrix_multiply.sv */
`timescale 1ns / 1ps
`default_nettype none

// Scaled matrix multiply, C = alpha*A*B + beta*C, signed Q8.8 throughout.
// Kind 0 and kind 1 transfers store one element of A or B and return
// nothing. A kind 2 transfer brings the old C element at (row, col) and
// returns the new one: one shared multiply-accumulate unit walks the
// inner_k products of the dot product one per cycle out of the A and B
// memories, then forms alpha*dot and beta*old in two more passes through
// the same unit. The dot product is exact, shifted right 8; the scaled sum
// is shifted right 8 and saturated. An update outside the configured sizes
// returns status 1 and value 0; an out-of-range load is dropped. Sizes
// above MAX_* act as MAX_*. The memories are not cleared; elements used by
// a dot product must have been loaded first. Configuration must be
// written only while idle; the block does not enforce it.
module scaled_matrix_multiply #(
    parameter int MAX_M = 8,
    parameter int MAX_K = 8,
    parameter int MAX_N = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [smm_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [smm_pkg::CFG_W-1:0]    cfg_wdata,
    // Input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,   // row[2:0], col[5:3], value[21:6]
    input  wire logic [1:0]                   s_tuser,   // kind[1:0]
    // Result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [23:0]                       m_tdata,   // out_row[2:0], out_col[5:3],
                                                         // out_value[21:6]
    output logic [0:0]                        m_tuser    // status[0]
);
    import smm_pkg::*;

    localparam int A_DEPTH = MAX_M * MAX_K;
    localparam int B_DEPTH = MAX_K * MAX_N;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int SUM_W   = 2 * VAL_W + 1 + $clog2(MAX_K);
    localparam int DOT_W   = SUM_W - 8;
    localparam int ACC_W   = VAL_W + DOT_W + 1;
    localparam int T_W     = ACC_W - 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_SCALE_A,
        ST_SCALE_B,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic signed [VAL_W-1:0]  alpha_reg;
    logic signed [VAL_W-1:0]  beta_reg;
    logic [SIZE_W-1:0]        rows_m_reg;
    logic [SIZE_W-1:0]        inner_k_reg;
    logic [SIZE_W-1:0]        cols_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= VAL_W'(256);
            beta_reg    <= '0;
            rows_m_reg  <= SIZE_W'(8);
            inner_k_reg <= SIZE_W'(8);
            cols_n_reg  <= SIZE_W'(8);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ALPHA:   alpha_reg   <= cfg_wdata;
                CFG_BETA:    beta_reg    <= cfg_wdata;
                CFG_ROWS_M:  rows_m_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_INNER_K: inner_k_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_COLS_N:  cols_n_reg  <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes, capped at the storage limits
    logic [LIM_W-1:0] m_lim;
    logic [LIM_W-1:0] k_lim;
    logic [LIM_W-1:0] n_lim;

    always_comb begin
        m_lim = (LIM_W'(rows_m_reg) > LIM_W'(MAX_M)) ? LIM_W'(MAX_M) : LIM_W'(rows_m_reg);
        k_lim = (LIM_W'(inner_k_reg) > LIM_W'(MAX_K)) ? LIM_W'(MAX_K) : LIM_W'(inner_k_reg);
        n_lim = (LIM_W'(cols_n_reg) > LIM_W'(MAX_N)) ? LIM_W'(MAX_N) : LIM_W'(cols_n_reg);
    end

    // Input fields
    kind_t                    in_kind;
    logic [IDX_W-1:0]         in_row;
    logic [IDX_W-1:0]         in_col;
    logic [VAL_W-1:0]         in_value;
    logic                     in_xfer;

    assign in_kind  = kind_t'(s_tuser);
    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    assign in_xfer  = s_tvalid && s_tready;

    // Range checks for the incoming transfer
    logic a_in_range;
    logic b_in_range;
    logic c_in_range;

    assign a_in_range = (LIM_W'(in_row) < m_lim) && (LIM_W'(in_col) < k_lim);
    assign b_in_range = (LIM_W'(in_row) < k_lim) && (LIM_W'(in_col) < n_lim);
    assign c_in_range = (LIM_W'(in_row) < m_lim) && (LIM_W'(in_col) < n_lim);

    // Sequencer registers
    state_t                   state_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic signed [VAL_W-1:0]  old_reg;
    logic [LIM_W-1:0]         k_reg;
    logic                     rd_vld_reg;
    logic                     rd_first_reg;
    logic                     err_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic                     m_tvalid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic [VAL_W-1:0]         out_value_reg;
    logic                     status_reg;

    // Memories for A and B
    logic                     a_we;
    logic                     b_we;
    logic [A_AW-1:0]          a_waddr;
    logic [B_AW-1:0]          b_waddr;
    logic [A_AW-1:0]          a_raddr;
    logic [B_AW-1:0]          b_raddr;
    logic [VAL_W-1:0]         a_rdata;
    logic [VAL_W-1:0]         b_rdata;

    assign a_we    = in_xfer && (in_kind == KIND_LOAD_A) && a_in_range;
    assign b_we    = in_xfer && (in_kind == KIND_LOAD_B) && b_in_range;
    assign a_waddr = A_AW'(in_row * MAX_K + in_col);
    assign b_waddr = B_AW'(in_row * MAX_N + in_col);
    assign a_raddr = A_AW'(row_reg * MAX_K + k_reg);
    assign b_raddr = B_AW'(k_reg * MAX_N + col_reg);

    smm_ram #(
        .DEPTH (A_DEPTH),
        .AW    (A_AW)
    ) u_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (in_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smm_ram #(
        .DEPTH (B_DEPTH),
        .AW    (B_AW)
    ) u_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (in_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Operand select for the shared multiply-accumulate
    mac_op_t                  mac_op;
    logic signed [VAL_W-1:0]  mac_x;
    logic signed [DOT_W-1:0]  mac_y;
    logic                     mac_busy;
    logic signed [ACC_W-1:0]  mac_acc;

    always_comb begin
        case (state_reg)
            ST_SCALE_A: begin
                mac_op = '{valid: 1'b1, clear: 1'b1};
                mac_x  = alpha_reg;
                mac_y  = dot_reg;
            end
            ST_SCALE_B: begin
                mac_op = '{valid: 1'b1, clear: 1'b0};
                mac_x  = beta_reg;
                mac_y  = DOT_W'(old_reg);
            end
            default: begin
                mac_op = '{valid: rd_vld_reg, clear: rd_first_reg};
                mac_x  = $signed(a_rdata);
                mac_y  = DOT_W'($signed(b_rdata));
            end
        endcase
    end

    smm_mac #(
        .Y_W   (DOT_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .x       (mac_x),
        .y       (mac_y),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    // Final shift and saturation of the scaled sum
    logic signed [T_W-1:0]    t_val;
    logic [VAL_W-1:0]         sat_val;

    assign t_val = mac_acc[ACC_W-1:8];

    always_comb begin
        if (t_val > $signed(T_W'(32767))) begin
            sat_val = 16'h7FFF;
        end else if (t_val < $signed(-T_W'(32768))) begin
            sat_val = 16'h8000;
        end else begin
            sat_val = t_val[VAL_W-1:0];
        end
    end

    // Output register can take a new result
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= (state_reg == ST_READ);
            rd_first_reg <= (state_reg == ST_READ) && (k_reg == '0);
            // Drop the result once taken, unless a new one loads in its place
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && (in_kind == KIND_UPDATE)) begin
                        row_reg <= in_row;
                        col_reg <= in_col;
                        old_reg <= in_value;
                        k_reg   <= '0;
                        dot_reg <= '0;
                        err_reg <= !c_in_range;
                        if (!c_in_range) begin
                            state_reg <= ST_FINISH;
                        end else if (k_lim == '0) begin
                            state_reg <= ST_SCALE_A;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    k_reg <= k_reg + LIM_W'(1);
                    if (k_reg == k_lim - LIM_W'(1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_vld_reg && !mac_busy) begin
                        dot_reg   <= mac_acc[SUM_W-1:8];
                        state_reg <= ST_SCALE_A;
                    end
                end
                ST_SCALE_A: begin
                    state_reg <= ST_SCALE_B;
                end
                ST_SCALE_B: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (!mac_busy) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        out_row_reg   <= row_reg;
                        out_col_reg   <= col_reg;
                        out_value_reg <= err_reg ? '0 : sat_val;
                        status_reg    <= err_reg ? STATUS_ERR : STATUS_OK;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser[0] = status_reg;

endmodule

`default_nettype wire
